/* hw/rtl/mdc_pkg.sv */
// shared types, codes and constants of the maze carver
package mdc_pkg;

  localparam int unsigned DEF_MAX_WIDTH   = 64;
  localparam int unsigned DEF_MAX_HEIGHT  = 64;
  localparam int unsigned DEF_RANDOM_BITS = 16;

  localparam int unsigned RAND_FIELD_W = 16;
  localparam int unsigned CFG_W        = 7;
  localparam int unsigned DIM_W        = 9;
  localparam int unsigned COORD_OUT_W  = 6;
  localparam int unsigned OPEN_W       = 3;
  localparam int unsigned ACT_W        = 2;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;
  localparam int unsigned OUT_DATA_W   = 32;

  localparam logic [CFG_W-1:0] RST_GRID_DIM = CFG_W'(16);

  // register select bit of paddr
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  // neighbour directions, in search order
  localparam logic [1:0] DIR_N = 2'd0;
  localparam logic [1:0] DIR_E = 2'd1;
  localparam logic [1:0] DIR_S = 2'd2;
  localparam logic [1:0] DIR_W = 2'd3;

  typedef enum logic [ACT_W-1:0] {
    ACT_CARVE = 2'd0,
    ACT_BACK  = 2'd1,
    ACT_IDLE  = 2'd2
  } mdc_action_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_N,
    ST_RD_E,
    ST_RD_S,
    ST_RD_W,
    ST_GATHER,
    ST_APPLY,
    ST_POP,
    ST_FINISH
  } mdc_state_e;

  typedef struct packed {
    logic       done;
    logic [1:0] res;
  } mdc_mod3_stat_t;

endpackage

/* hw/rtl/mdc_mod3.sv */
// iterative residue-mod-3 unit, two bits of the value per cycle
module mdc_mod3 #(
  parameter int unsigned VAL_W = mdc_pkg::RAND_FIELD_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [VAL_W-1:0]     value_i,
  output mdc_pkg::mdc_mod3_stat_t stat_o
);

  localparam int unsigned NDIG  = (VAL_W + 1) / 2;
  localparam int unsigned SH_W  = 2 * NDIG;
  localparam int unsigned CNT_W = $clog2(NDIG + 1);

  logic [SH_W-1:0]  sh_q, sh_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       res_q, res_d;
  logic [2:0]       sum;

  // 4 = 1 mod 3, so base-4 digits simply add up
  always_comb begin
    sum   = {1'b0, res_q} + {1'b0, sh_q[1:0]};
    sh_d  = sh_q;
    cnt_d = cnt_q;
    res_d = res_q;
    if (start_i) begin
      sh_d  = SH_W'(value_i);
      cnt_d = CNT_W'(NDIG);
      res_d = 2'd0;
    end else if (cnt_q != '0) begin
      sh_d  = sh_q >> 2;
      cnt_d = cnt_q - 1'b1;
      res_d = (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sh_q  <= '0;
      cnt_q <= '0;
      res_q <= '0;
    end else begin
      sh_q  <= sh_d;
      cnt_q <= cnt_d;
      res_q <= res_d;
    end
  end

  assign stat_o.done = (cnt_q == '0);
  assign stat_o.res  = res_q;

endmodule

/* hw/rtl/maze_dfs_carver.sv */
// maze carver top level: depth-first walk with visited map and backtrack stack
//
//  channel   dir  beat contents
//  s_axis    in   tdata[15:0] random_value
//  m_axis    out  tuser[1:0] action; tdata from_x, from_y, to_x, to_y, open_choices, maze_done
//  apb       in   reg 0 grid_width at 0x0, reg 1 grid_height at 0x4
//
//  a step that finds the maze complete goes straight to the result; a carve or backtrack first
//  reads the four neighbours in turn through the single visited-map read port and waits for
//  the mod-3 unit at two bits per cycle, then passes through a pop state when it pops the stack
//  after reset all 2**(clog2(MAX_WIDTH)+clog2(MAX_HEIGHT)) visited-map entries (4096 by default)
//  are cleared, cell 0 marked visited, with s_axis_tready low; apb writes are taken meanwhile
//  the next beat is accepted while a result still waits; a step then holds until it is taken
module maze_dfs_carver #(
  parameter int unsigned MAX_WIDTH   = mdc_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT  = mdc_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned RANDOM_BITS = mdc_pkg::DEF_RANDOM_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] random_value
  input  logic [mdc_pkg::RAND_FIELD_W-1:0] s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [5:0] from_x, [11:6] from_y, [17:12] to_x, [23:18] to_y,
  // [26:24] open_choices, [27] maze_done, [31:28] zero
  output logic [mdc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // [1:0] action
  output logic [mdc_pkg::ACT_W-1:0]        m_axis_tuser,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [mdc_pkg::PADDR_W-1:0]      paddr,
  input  logic [mdc_pkg::PDATA_W-1:0]      pwdata,
  output logic [mdc_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int unsigned XW    = $clog2(MAX_WIDTH);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT);
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned LW    = WW + HW;
  localparam int unsigned RND_W = (RANDOM_BITS < mdc_pkg::RAND_FIELD_W) ?
                                  RANDOM_BITS : mdc_pkg::RAND_FIELD_W;

  // configuration
  logic [mdc_pkg::CFG_W-1:0] grid_width_q, grid_height_q;
  logic                      cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= mdc_pkg::RST_GRID_DIM;
      grid_height_q <= mdc_pkg::RST_GRID_DIM;
    end else if (cfg_we) begin
      if (paddr[2] == mdc_pkg::REG_GRID_WIDTH) begin
        grid_width_q <= pwdata[mdc_pkg::CFG_W-1:0];
      end else begin
        grid_height_q <= pwdata[mdc_pkg::CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == mdc_pkg::REG_GRID_WIDTH) begin
      prdata = mdc_pkg::PDATA_W'(grid_width_q);
    end else begin
      prdata = mdc_pkg::PDATA_W'(grid_height_q);
    end
  end

  // effective dimensions
  logic [mdc_pkg::DIM_W-1:0] w_ext, h_ext, w_cl, h_cl;
  logic [WW-1:0]             dim_w;
  logic [HW-1:0]             dim_h;
  logic [LW-1:0]             last_cell;

  always_comb begin
    w_ext = mdc_pkg::DIM_W'(grid_width_q);
    h_ext = mdc_pkg::DIM_W'(grid_height_q);
    if (w_ext == '0) begin
      w_cl = mdc_pkg::DIM_W'(1);
    end else if (w_ext > mdc_pkg::DIM_W'(MAX_WIDTH)) begin
      w_cl = mdc_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      w_cl = w_ext;
    end
    if (h_ext == '0) begin
      h_cl = mdc_pkg::DIM_W'(1);
    end else if (h_ext > mdc_pkg::DIM_W'(MAX_HEIGHT)) begin
      h_cl = mdc_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      h_cl = h_ext;
    end
    dim_w     = WW'(w_cl);
    dim_h     = HW'(h_cl);
    last_cell = LW'(dim_w) * LW'(dim_h) - LW'(1);
  end

  // state
  mdc_pkg::mdc_state_e     state_q, state_d;
  logic [AW-1:0]           clr_q;
  logic [XW-1:0]           cur_x_q, from_x_q;
  logic [YW-1:0]           cur_y_q, from_y_q;
  logic [AW-1:0]           carved_q;
  logic [AW:0]             depth_q;
  logic [RND_W-1:0]        rnd_q;
  logic [3:0]              open_q;
  mdc_pkg::mdc_action_e    act_q;

  logic                    m_valid_q;
  mdc_pkg::mdc_action_e    out_act_q;
  logic [mdc_pkg::COORD_OUT_W-1:0] out_fx_q, out_fy_q, out_tx_q, out_ty_q;
  logic [mdc_pkg::OPEN_W-1:0]      out_open_q;
  logic                            out_done_q;

  logic                    accept, done_now, fin_load;
  logic                    go, carve, back, pop;
  mdc_pkg::mdc_mod3_stat_t mod_stat;

  // neighbours of the current cell
  logic [XW-1:0] nb_x [4];
  logic [YW-1:0] nb_y [4];
  logic [3:0]    inbound;

  always_comb begin
    nb_x[mdc_pkg::DIR_N] = cur_x_q;
    nb_y[mdc_pkg::DIR_N] = cur_y_q - 1'b1;
    nb_x[mdc_pkg::DIR_E] = cur_x_q + 1'b1;
    nb_y[mdc_pkg::DIR_E] = cur_y_q;
    nb_x[mdc_pkg::DIR_S] = cur_x_q;
    nb_y[mdc_pkg::DIR_S] = cur_y_q + 1'b1;
    nb_x[mdc_pkg::DIR_W] = cur_x_q - 1'b1;
    nb_y[mdc_pkg::DIR_W] = cur_y_q;
    inbound[mdc_pkg::DIR_N] = (cur_y_q != '0);
    inbound[mdc_pkg::DIR_E] = ((WW'(cur_x_q) + WW'(1)) < dim_w);
    inbound[mdc_pkg::DIR_S] = ((HW'(cur_y_q) + HW'(1)) < dim_h);
    inbound[mdc_pkg::DIR_W] = (cur_x_q != '0);
  end

  // choice among the open neighbours
  logic [mdc_pkg::OPEN_W-1:0] open_cnt, seen;
  logic [1:0]                 pick, sel_dir;

  always_comb begin
    open_cnt = mdc_pkg::OPEN_W'(open_q[0]) + mdc_pkg::OPEN_W'(open_q[1]) +
               mdc_pkg::OPEN_W'(open_q[2]) + mdc_pkg::OPEN_W'(open_q[3]);
    case (open_cnt)
      3'd2:    pick = {1'b0, rnd_q[0]};
      3'd3:    pick = mod_stat.res;
      3'd4:    pick = rnd_q[1:0];
      default: pick = 2'd0;
    endcase
    sel_dir = mdc_pkg::DIR_N;
    seen    = '0;
    for (int d = 0; d < 4; d++) begin
      if (open_q[d]) begin
        if (seen == mdc_pkg::OPEN_W'(pick)) begin
          sel_dir = 2'(d);
        end
        seen = seen + 1'b1;
      end
    end
  end

  mdc_mod3 #(
    .VAL_W(RND_W)
  ) u_mod3 (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .value_i(s_axis_tdata[RND_W-1:0]),
    .stat_o (mod_stat)
  );

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign done_now = (LW'(carved_q) >= last_cell);
  assign go       = (state_q == mdc_pkg::ST_APPLY) && mod_stat.done;
  assign carve    = go && (open_cnt != '0);
  assign back     = go && (open_cnt == '0);
  assign pop      = back && (depth_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      mdc_pkg::ST_CLEAR:  if (clr_q == {AW{1'b1}}) state_d = mdc_pkg::ST_IDLE;
      mdc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = done_now ? mdc_pkg::ST_FINISH : mdc_pkg::ST_RD_N;
        end
      end
      mdc_pkg::ST_RD_N:   state_d = mdc_pkg::ST_RD_E;
      mdc_pkg::ST_RD_E:   state_d = mdc_pkg::ST_RD_S;
      mdc_pkg::ST_RD_S:   state_d = mdc_pkg::ST_RD_W;
      mdc_pkg::ST_RD_W:   state_d = mdc_pkg::ST_GATHER;
      mdc_pkg::ST_GATHER: state_d = mdc_pkg::ST_APPLY;
      mdc_pkg::ST_APPLY: begin
        if (go) begin
          state_d = pop ? mdc_pkg::ST_POP : mdc_pkg::ST_FINISH;
        end
      end
      mdc_pkg::ST_POP:    state_d = mdc_pkg::ST_FINISH;
      mdc_pkg::ST_FINISH: if (fin_load) state_d = mdc_pkg::ST_IDLE;
      default:            state_d = mdc_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  logic          vis_we, vis_wdata, cap_en;
  logic [AW-1:0] vis_waddr, vis_raddr;
  logic [1:0]    rd_dir, cap_dir;

  always_comb begin
    s_axis_tready = 1'b0;
    fin_load      = 1'b0;
    vis_we        = 1'b0;
    vis_wdata     = 1'b0;
    vis_waddr     = clr_q;
    rd_dir        = mdc_pkg::DIR_N;
    cap_en        = 1'b0;
    cap_dir       = mdc_pkg::DIR_N;
    case (state_q)
      mdc_pkg::ST_CLEAR: begin
        vis_we    = 1'b1;
        vis_wdata = (clr_q == '0);
      end
      mdc_pkg::ST_IDLE:   s_axis_tready = 1'b1;
      mdc_pkg::ST_RD_N:   rd_dir = mdc_pkg::DIR_N;
      mdc_pkg::ST_RD_E: begin
        rd_dir  = mdc_pkg::DIR_E;
        cap_en  = 1'b1;
        cap_dir = mdc_pkg::DIR_N;
      end
      mdc_pkg::ST_RD_S: begin
        rd_dir  = mdc_pkg::DIR_S;
        cap_en  = 1'b1;
        cap_dir = mdc_pkg::DIR_E;
      end
      mdc_pkg::ST_RD_W: begin
        rd_dir  = mdc_pkg::DIR_W;
        cap_en  = 1'b1;
        cap_dir = mdc_pkg::DIR_S;
      end
      mdc_pkg::ST_GATHER: begin
        cap_en  = 1'b1;
        cap_dir = mdc_pkg::DIR_W;
      end
      mdc_pkg::ST_APPLY: begin
        vis_we    = carve;
        vis_wdata = 1'b1;
        vis_waddr = {nb_y[sel_dir], nb_x[sel_dir]};
      end
      mdc_pkg::ST_FINISH: fin_load = !m_valid_q || m_axis_tready;
      default: ;
    endcase
    vis_raddr = {nb_y[rd_dir], nb_x[rd_dir]};
  end

  // visited map
  logic vis_mem [DEPTH];
  logic vis_rd_q;

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_waddr] <= vis_wdata;
    end
    vis_rd_q <= vis_mem[vis_raddr];
  end

  // backtrack stack, cells stored as {y, x}
  logic [AW-1:0] stk_mem [DEPTH];
  logic [AW-1:0] stk_rd_q;
  logic [AW:0]   depth_dec;

  assign depth_dec = depth_q - 1'b1;

  always_ff @(posedge clk_i) begin
    if (carve) begin
      stk_mem[depth_q[AW-1:0]] <= {cur_y_q, cur_x_q};
    end
    if (pop) begin
      stk_rd_q <= stk_mem[depth_dec[AW-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mdc_pkg::ST_CLEAR;
      clr_q     <= '0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
      carved_q  <= '0;
      depth_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == mdc_pkg::ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (carve) begin
        cur_x_q  <= nb_x[sel_dir];
        cur_y_q  <= nb_y[sel_dir];
        carved_q <= carved_q + 1'b1;
        depth_q  <= depth_q + 1'b1;
      end else if (pop) begin
        depth_q <= depth_dec;
      end
      if (state_q == mdc_pkg::ST_POP) begin
        cur_x_q <= stk_rd_q[XW-1:0];
        cur_y_q <= stk_rd_q[AW-1:XW];
      end
      if (fin_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // step payload and result beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      from_x_q <= cur_x_q;
      from_y_q <= cur_y_q;
      rnd_q    <= s_axis_tdata[RND_W-1:0];
      open_q   <= '0;
      act_q    <= mdc_pkg::ACT_IDLE;
    end
    if (cap_en) begin
      open_q[cap_dir] <= inbound[cap_dir] && !vis_rd_q;
    end
    if (go) begin
      act_q <= carve ? mdc_pkg::ACT_CARVE : mdc_pkg::ACT_BACK;
    end
    if (fin_load) begin
      out_act_q  <= act_q;
      out_fx_q   <= mdc_pkg::COORD_OUT_W'(from_x_q);
      out_fy_q   <= mdc_pkg::COORD_OUT_W'(from_y_q);
      out_tx_q   <= mdc_pkg::COORD_OUT_W'(cur_x_q);
      out_ty_q   <= mdc_pkg::COORD_OUT_W'(cur_y_q);
      out_open_q <= open_cnt;
      out_done_q <= done_now;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_act_q;
  assign m_axis_tdata  = mdc_pkg::OUT_DATA_W'({out_done_q, out_open_q, out_ty_q, out_tx_q,
                                               out_fy_q, out_fx_q});

  a_carve_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    carve |=> (depth_q == $past(depth_q) + 1'b1))
    else $error("carve step did not push the stack");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= (AW + 1)'(carved_q))
    else $error("stack deeper than carved passages");

  a_carve_has_choice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (out_act_q == mdc_pkg::ACT_CARVE)) |-> (out_open_q != '0))
    else $error("carve result without open neighbour");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && done_now) |=> (state_q == mdc_pkg::ST_FINISH && $stable(carved_q)))
    else $error("step on a complete maze changed state");

endmodule
